// ----- src/plc_pkg.sv -----
// Package for the piecewise linear calibrator: constants, payload structs,
// controller state and the command and status structs between the two halves.
// Depends on nothing; plc_ctrl, plc_datapath and the top level import it.
`default_nettype none

package plc_pkg;

    // Sizes of the bin store.
    localparam int NUM_LISTS = 64;
    localparam int MAX_BINS  = 32;
    localparam int FRAC_BITS = 16;
    localparam int LIST_W    = $clog2(NUM_LISTS);
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int CNT_W     = $clog2(MAX_BINS + 1);
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int STEP_W    = $clog2(VAL_W);
    localparam int BIN_ADDR_W = LIST_W + BIN_W;

    // Fixed point one.
    localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_CAL = 1'b1;

    typedef struct packed {
        logic              action;
        logic [LIST_W-1:0] list_index;
        logic [VAL_W-1:0]  point;
        logic [VAL_W-1:0]  bin_probability;
    } t_item;

    typedef struct packed {
        logic [VAL_W-1:0] calibrated;
        t_status          status;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_SCAN,
        S_CALC,
        S_MUL,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    // Which result the datapath loads into its output register.
    typedef enum logic [2:0] {
        RS_NONE,
        RS_OK,
        RS_FULL,
        RS_EMPTY,
        RS_LO,
        RS_FINAL
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     add_write;
        logic     scan_init;
        logic     scan_step;
        logic     calc;
        logic     mul;
        logic     div_step;
        t_res_sel res;
    } t_cmd;

    typedef struct packed {
        logic is_add;
        logic full;
        logic empty;
        logic scan_end;
        logic trivial;
        logic div_last;
    } t_stat;

    // Saturate a Q value to one.
    function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
        sat_one = (v > ONE) ? ONE : v;
    endfunction

endpackage

`default_nettype wire

// ----- src/plc_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module plc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/plc_ctrl.sv -----
// Controller state machine of the calibrator: sequences count lookup, bin scan,
// multiply, serial divide and result strobe. Depends on plc_pkg.
`default_nettype none

module plc_ctrl import plc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res = RS_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_COUNT;
                end
            end
            S_COUNT: begin
                if (i_stat.is_add) begin
                    if (i_stat.full) begin
                        o_cmd.res = RS_FULL;
                    end else begin
                        o_cmd.add_write = 1'b1;
                        o_cmd.res       = RS_OK;
                    end
                    n_state = S_DONE;
                end else if (i_stat.empty) begin
                    o_cmd.res = RS_EMPTY;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (i_stat.trivial) begin
                    o_cmd.res = RS_LO;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.calc = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.res = RS_FINAL;
                n_state   = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

`default_nettype wire

// ----- src/plc_datapath.sv -----
// Datapath of the calibrator: bin and count memories, scan registers, one
// multiplier, a restoring divider and the result register. Depends on plc_pkg, plc_ram.
`default_nettype none

module plc_datapath import plc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_item i_item,
    input  wire t_cmd  i_cmd,
    output t_stat      o_stat,
    output t_result    o_result
);

    logic                  r_add;
    logic [LIST_W-1:0]     r_list;
    logic [VAL_W-1:0]      r_point, r_prob;
    logic [CNT_W-1:0]      r_cnt;
    logic [BIN_W-1:0]      r_k;
    logic [VAL_W-1:0]      r_lo_t, r_lo_p, r_hi_t, r_hi_p;
    logic [VAL_W-1:0]      r_num, r_diff, r_den;
    logic                  r_up;
    logic [VAL_W-1:0]      r_rem, r_low;
    logic [STEP_W-1:0]     r_step;
    t_result               r_res;
    logic [NUM_LISTS-1:0]  r_cnt_vld;

    logic [CNT_W-1:0]      cnt_q, cnt_cur;
    logic [2*VAL_W-1:0]    bin_q;
    logic [BIN_ADDR_W-1:0] bin_raddr;
    logic [VAL_W-1:0]      bin_t, bin_p;
    logic                  hit, last;
    logic [VAL_W-1:0]      den, num_raw;
    logic [2*VAL_W-1:0]    prod;
    logic [VAL_W:0]        trial;
    logic [VAL_W:0]        up_sum;
    logic [VAL_W-1:0]      final_val;

    // Count memory; a list never written reads as empty.
    plc_ram #(.WIDTH(CNT_W), .DEPTH(NUM_LISTS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_write),
        .i_waddr (r_list),
        .i_wdata (cnt_cur + CNT_W'(1)),
        .i_raddr (i_item.list_index),
        .o_rdata (cnt_q)
    );

    assign cnt_cur = r_cnt_vld[r_list] ? cnt_q : '0;

    // Bin memory, threshold in the upper half, probability in the lower.
    assign bin_raddr = i_cmd.scan_init ? {r_list, BIN_W'(0)}
                                       : {r_list, r_k + BIN_W'(1)};

    plc_ram #(.WIDTH(2*VAL_W), .DEPTH(NUM_LISTS*MAX_BINS)) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_write),
        .i_waddr ({r_list, cnt_cur[BIN_W-1:0]}),
        .i_wdata ({r_point, r_prob}),
        .i_raddr (bin_raddr),
        .o_rdata (bin_q)
    );

    assign bin_t = bin_q[2*VAL_W-1:VAL_W];
    assign bin_p = bin_q[VAL_W-1:0];
    assign hit   = (bin_t >= r_point);
    assign last  = (({1'b0, r_k} + CNT_W'(1)) == r_cnt);

    // Interval terms.
    assign den     = r_hi_t - r_lo_t;
    assign num_raw = r_point - r_lo_t;
    assign prod    = r_num * r_diff;
    assign trial   = {r_rem, r_low[VAL_W-1]};

    // Final combine of the quotient with the lower probability.
    assign up_sum = {1'b0, r_lo_p} + {1'b0, r_low};
    always_comb begin
        if (r_up) begin
            final_val = (up_sum > {1'b0, ONE}) ? ONE : up_sum[VAL_W-1:0];
        end else begin
            final_val = (r_low > r_lo_p) ? '0 : (r_lo_p - r_low);
        end
    end

    // Count valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (i_cmd.add_write) begin
            r_cnt_vld[r_list] <= 1'b1;
        end
    end

    // Item, scan, arithmetic and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_add   <= (i_item.action == ACT_ADD);
            r_list  <= i_item.list_index;
            r_point <= sat_one(i_item.point);
            r_prob  <= sat_one(i_item.bin_probability);
        end
        if (i_cmd.scan_init) begin
            r_cnt  <= cnt_cur;
            r_k    <= '0;
            r_lo_t <= '0;
            r_lo_p <= '0;
        end
        if (i_cmd.scan_step) begin
            if (hit) begin
                r_hi_t <= bin_t;
                r_hi_p <= bin_p;
            end else begin
                r_lo_t <= bin_t;
                r_lo_p <= bin_p;
                if (last) begin
                    r_hi_t <= ONE;
                    r_hi_p <= ONE;
                end else begin
                    r_k <= r_k + BIN_W'(1);
                end
            end
        end
        if (i_cmd.calc) begin
            r_den  <= den;
            r_num  <= (num_raw > den) ? den : num_raw;
            r_up   <= (r_hi_p >= r_lo_p);
            r_diff <= (r_hi_p >= r_lo_p) ? (r_hi_p - r_lo_p) : (r_lo_p - r_hi_p);
        end
        // The quotient fits VAL_W bits, so the upper half is the first remainder.
        if (i_cmd.mul) begin
            r_rem  <= prod[2*VAL_W-1:VAL_W];
            r_low  <= prod[VAL_W-1:0];
            r_step <= '0;
        end
        if (i_cmd.div_step) begin
            r_step <= r_step + STEP_W'(1);
            if (trial >= {1'b0, r_den}) begin
                r_rem <= VAL_W'(trial - {1'b0, r_den});
                r_low <= {r_low[VAL_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[VAL_W-1:0];
                r_low <= {r_low[VAL_W-2:0], 1'b0};
            end
        end
        unique case (i_cmd.res)
            RS_OK: begin
                r_res.calibrated <= '0;
                r_res.status     <= ST_OK;
            end
            RS_FULL: begin
                r_res.calibrated <= '0;
                r_res.status     <= ST_FULL;
            end
            RS_EMPTY: begin
                r_res.calibrated <= '0;
                r_res.status     <= ST_EMPTY;
            end
            RS_LO: begin
                r_res.calibrated <= r_lo_p;
                r_res.status     <= ST_OK;
            end
            RS_FINAL: begin
                r_res.calibrated <= final_val;
                r_res.status     <= ST_OK;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    // Status toward the controller.
    assign o_stat.is_add   = r_add;
    assign o_stat.full     = (cnt_cur >= CNT_W'(MAX_BINS));
    assign o_stat.empty    = (cnt_cur == '0);
    assign o_stat.scan_end = hit || last;
    assign o_stat.trivial  = (r_hi_t <= r_lo_t) || (r_point <= r_lo_t);
    assign o_stat.div_last = (r_step == STEP_W'(VAL_W - 1));

    assign o_result = r_res;

endmodule

`default_nettype wire

// ----- src/piecewise_linear_calibrator.sv -----
// Top level of the piecewise linear calibrator: controller plus datapath.
// Depends on plc_pkg, plc_ctrl, plc_datapath.
//
// An item is taken at a rising edge where start is high and busy is low; its one
// result is on o_result for a single cycle with o_done high and must be captured
// then, since the receiver cannot stall the block. An add, and a calibrate on an
// empty list, go from the count lookup straight to the strobe. A calibrate scans
// its list one bin a cycle through the bin memory read port until the first
// threshold at least the point or the last bin, k bins in all (1 to 32); it then
// forms the interval terms, multiplies, runs the serial divider, combines the
// quotient with the lower probability and strobes the result. When the interval
// has zero width or the point sits at the lower threshold, it goes from the
// interval terms straight to the strobe of the lower probability. One item is
// worked on at a time; busy drops the cycle after the strobe, so the next item
// can be taken in the cycle after the result.
`default_nettype none

module piecewise_linear_calibrator import plc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire t_item i_item,
    output logic       busy,
    output logic       o_done,
    output t_result    o_result
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    plc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Storage and arithmetic.
    plc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for the piecewise linear calibrator: directed and random add and
// calibrate transfers, checked against an in-bench bin-list predictor.
// Depends on plc_pkg and piecewise_linear_calibrator.
`timescale 1ns / 1ps

module testbench;
    import plc_pkg::*;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_done;
    t_result o_result;

    int      fail_count;
    t_result expected_results[$];

    // Predictor copy of the bin store.
    logic [VAL_W-1:0] pred_thr  [NUM_LISTS][MAX_BINS];
    logic [VAL_W-1:0] pred_prob [NUM_LISTS][MAX_BINS];
    int               pred_count[NUM_LISTS];

    piecewise_linear_calibrator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run time limit.
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // Interpolate a calibrated probability for one list.
    function automatic logic [VAL_W-1:0] calibrate_point(int lst, logic [VAL_W-1:0] p);
        int          n;
        int          k;
        longint      lo_t, lo_p, hi_t, hi_p, num, den, res, dec;
        n = pred_count[lst];
        k = 0;
        while (k < n && pred_thr[lst][k] < p)
            k++;
        lo_t = (k > 0) ? pred_thr[lst][k-1] : 0;
        lo_p = (k > 0) ? pred_prob[lst][k-1] : 0;
        hi_t = (k < n) ? pred_thr[lst][k] : ONE;
        hi_p = (k < n) ? pred_prob[lst][k] : ONE;
        if (hi_t <= lo_t || p <= lo_t)
            return (lo_p > ONE) ? ONE : VAL_W'(lo_p);
        den = hi_t - lo_t;
        num = p - lo_t;
        if (num > den)
            num = den;
        if (hi_p >= lo_p) begin
            res = lo_p + (num * (hi_p - lo_p)) / den;
        end else begin
            dec = (num * (lo_p - hi_p)) / den;
            res = (dec > lo_p) ? 0 : lo_p - dec;
        end
        return (res > ONE) ? ONE : VAL_W'(res);
    endfunction

    // Update the predicted store and return the expected result of one item.
    function automatic t_result predict_result(t_item it);
        t_result          r;
        logic [VAL_W-1:0] pt, pr;
        int               lst;
        pt = (it.point > ONE) ? ONE : it.point;
        pr = (it.bin_probability > ONE) ? ONE : it.bin_probability;
        lst = it.list_index;
        r.calibrated = '0;
        r.status = ST_OK;
        if (it.action == ACT_ADD) begin
            if (lst >= NUM_LISTS || pred_count[lst] >= MAX_BINS) begin
                r.status = ST_FULL;
            end else begin
                pred_thr[lst][pred_count[lst]] = pt;
                pred_prob[lst][pred_count[lst]] = pr;
                pred_count[lst]++;
            end
        end else begin
            if (lst >= NUM_LISTS || pred_count[lst] == 0)
                r.status = ST_EMPTY;
            else
                r.calibrated = calibrate_point(lst, pt);
        end
        return r;
    endfunction

    // Send one item after a random gap; the expectation is queued at the transfer.
    // Start stays high into the next item when that one follows with no gap.
    task automatic send_item(logic act, int lst, logic [VAL_W-1:0] pt,
                             logic [VAL_W-1:0] pr);
        int gap;
        t_item it;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.action = act;
        it.list_index = LIST_W'(lst);
        it.point = pt;
        it.bin_probability = pr;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results.push_back(predict_result(it));
    endtask

    // Random Q16 value, with the extremes and out-of-range values often.
    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ONE;
            2: return VAL_W'($urandom_range(ONE + 1, (1 << VAL_W) - 1));
            default: return VAL_W'($urandom_range(0, ONE));
        endcase
    endfunction

    // Check each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: calibrated %0d status %0d",
                       o_result.calibrated, o_result.status);
                fail_count++;
            end else begin
                t_result e;
                e = expected_results.pop_front();
                if (o_result.calibrated !== e.calibrated) begin
                    $error("calibrated: expected %0d actual %0d",
                           e.calibrated, o_result.calibrated);
                    fail_count++;
                end
                if (o_result.status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_result.status);
                    fail_count++;
                end
            end
        end
    end

    // Edge cases on a few lists: empty, zero-width, descending, full, extremes.
    task automatic test_directed();
        int b;
        send_item(ACT_CAL, 0, 17'd1000, '0);
        send_item(ACT_ADD, 0, 17'd16384, 17'd8192);
        send_item(ACT_ADD, 0, 17'd16384, 17'd40000);
        send_item(ACT_ADD, 0, 17'd49152, 17'd20000);
        send_item(ACT_CAL, 0, '0, '1);
        send_item(ACT_CAL, 0, 17'd8000, '0);
        send_item(ACT_CAL, 0, 17'd16384, '0);
        send_item(ACT_CAL, 0, 17'd30000, '0);
        send_item(ACT_CAL, 0, 17'd60000, '0);
        send_item(ACT_CAL, 0, ONE, '0);
        send_item(ACT_CAL, 0, '1, '0);
        send_item(ACT_ADD, 63, '1, '1);
        send_item(ACT_CAL, 63, 17'd100, '0);
        send_item(ACT_CAL, 63, '1, '0);
        send_item(ACT_ADD, 62, ONE, '0);
        send_item(ACT_CAL, 62, 17'd5, '0);
        for (b = 0; b < MAX_BINS; b++)
            send_item(ACT_ADD, 1, VAL_W'(b * 2000), VAL_W'($urandom_range(0, ONE)));
        send_item(ACT_ADD, 1, 17'd3, 17'd3);
        send_item(ACT_CAL, 1, 17'd33333, '0);
        send_item(ACT_CAL, 1, ONE, '0);
    endtask

    // Random mix, mostly calibrates on lists with bins mostly in ascending order.
    task automatic test_random(int count);
        int i, lst;
        logic [VAL_W-1:0] pt;
        for (i = 0; i < count; i++) begin
            lst = $urandom_range(0, NUM_LISTS - 1);
            if ($urandom_range(0, 2) == 0) begin
                if (pred_count[lst] > 0 && $urandom_range(0, 4) != 0)
                    pt = pred_thr[lst][pred_count[lst]-1]
                         + VAL_W'($urandom_range(0, 4000));
                else
                    pt = rand_value();
                send_item(ACT_ADD, lst, pt, rand_value());
            end else begin
                send_item(ACT_CAL, lst, rand_value(), VAL_W'($urandom));
            end
        end
    endtask

    initial begin
        int k;
        fail_count = 0;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        for (k = 0; k < NUM_LISTS; k++)
            pred_count[k] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(1500);
        start <= 1'b0;

        k = 0;
        while (expected_results.size() != 0 && k < 2000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
